[design/pps_pkg.sv]
// Shared types and constants of the preemptive priority scheduler.
package pps_pkg;

  localparam int unsigned ARR_W    = 16;
  localparam int unsigned BST_W    = 16;
  localparam int unsigned PRI_W    = 8;
  localparam int unsigned ID_W     = 4;
  localparam int unsigned TIME_W   = 32;
  localparam int unsigned STATUS_W = 2;

  // arrival, burst, priority_req: 40 bits, already whole bytes
  localparam int unsigned IN_DATA_W  = ARR_W + BST_W + PRI_W;
  localparam int unsigned IN_USER_W  = 1;
  // job_id, finished, turnaround, waiting, all_done, now: 102 bits, padded to 104
  localparam int unsigned OUT_FLD_W  = ID_W + 1 + TIME_W + TIME_W + 1 + TIME_W;
  localparam int unsigned OUT_DATA_W = ((OUT_FLD_W + 7) / 8) * 8;
  localparam int unsigned OUT_USER_W = STATUS_W;

  typedef logic [STATUS_W-1:0] status_t;

  localparam status_t ST_LOADED = 2'd0;
  localparam status_t ST_RAN    = 2'd1;
  localparam status_t ST_IDLE   = 2'd2;
  localparam status_t ST_REJECT = 2'd3;

  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_TICK = 1'b1;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_SCAN   = 6'b000010,
    S_FETCH  = 6'b000100,
    S_UPDATE = 6'b001000,
    S_CALC   = 6'b010000,
    S_RESULT = 6'b100000
  } state_t;

endpackage

[design/preemptive_priority_scheduler_unit.sv]
// Top level of the preemptive priority scheduler: job tables, scan sequencer and result register.
//
// Usage: items enter on the in_ stream. in_tuser selects the kind of item:
//   load (0) appends a job with arrival, burst and priority from in_tdata;
//   tick (1) advances time one step and runs the most urgent ready job.
// Every item gives exactly one result on the out_ stream; out_tuser carries
// the status (loaded, ran, idle, rejected), out_tdata the job id, the
// finished flag, turnaround and waiting times, all_done and the time now.
// A load goes straight to the result step. A tick walks the job table
// one entry per cycle through the shared compare unit and its registered
// table read, then advances the clock, decrements the remaining burst when
// a job runs and works out turnaround and waiting when it completes.
// One item is in flight at a time: in_tready is high only while the
// sequencer is idle, so a new item waits until the last one has left it.
// The result sits in an output register; the next item is accepted while
// it waits. If the receiver stalls, a finished item holds in the
// sequencer until the register empties.
// Reset (rst_n low, synchronous) clears the job count, the completion
// count, the clock and the output valid; the tables are not cleared,
// only entries below the job count are ever used.
module preemptive_priority_scheduler_unit #(
  parameter int unsigned MAX_PROCESSES = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // [15:0] arrival, [31:16] burst, [39:32] priority_req
  input  logic [pps_pkg::IN_DATA_W-1:0]   in_tdata,
  // [0] mode
  input  logic [pps_pkg::IN_USER_W-1:0]   in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // [3:0] job_id, [4] finished, [36:5] turnaround, [68:37] waiting,
  // [69] all_done, [101:70] now, [103:102] zero
  output logic [pps_pkg::OUT_DATA_W-1:0]  out_tdata,
  // [1:0] status
  output logic [pps_pkg::OUT_USER_W-1:0]  out_tuser
);
  import pps_pkg::*;

  localparam int unsigned IW = (MAX_PROCESSES > 1) ? $clog2(MAX_PROCESSES) : 1;
  localparam int unsigned CW = $clog2(MAX_PROCESSES + 1);
  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_PROCESSES);

  // job tables, one entry per job
  logic [ARR_W-1:0] arr_mem [MAX_PROCESSES];
  logic [BST_W-1:0] bst_mem [MAX_PROCESSES];
  logic [BST_W-1:0] rem_mem [MAX_PROCESSES];
  logic [PRI_W-1:0] pri_mem [MAX_PROCESSES];

  // registered read data of the tables
  logic [ARR_W-1:0] arr_q_r;
  logic [BST_W-1:0] bst_q_r;
  logic [BST_W-1:0] rem_q_r;
  logic [PRI_W-1:0] pri_q_r;

  state_t state_r, state_nxt;

  logic [CW-1:0]     job_cnt_r, job_cnt_nxt;
  logic [CW-1:0]     done_cnt_r, done_cnt_nxt;
  logic [TIME_W-1:0] clock_r, clock_nxt;

  logic [CW-1:0]     scan_cnt_r, scan_cnt_nxt;
  logic              cmp_v_r, cmp_v_nxt;
  logic [IW-1:0]     cmp_idx_r, cmp_idx_nxt;
  logic              found_r, found_nxt;
  logic [IW-1:0]     best_r, best_nxt;
  logic [PRI_W-1:0]  best_pri_r, best_pri_nxt;
  logic [TIME_W-1:0] tat_r, tat_nxt;

  // result being built
  status_t           res_status_r, res_status_nxt;
  logic [ID_W-1:0]   res_id_r, res_id_nxt;
  logic              res_fin_r, res_fin_nxt;
  logic [TIME_W-1:0] res_tat_r, res_tat_nxt;
  logic [TIME_W-1:0] res_wt_r, res_wt_nxt;

  // output register
  logic                  out_valid_r, out_valid_nxt;
  logic [OUT_DATA_W-1:0] out_data_r, out_data_nxt;
  status_t               out_user_r, out_user_nxt;

  logic              in_acc;
  logic              load_ok;
  logic              load_we;
  logic              rem_we;
  logic [IW-1:0]     rem_waddr;
  logic [BST_W-1:0]  rem_wdata;
  logic [IW-1:0]     rd_addr;
  logic              issue;
  logic              eligible;
  logic [BST_W-1:0]  rem_dec;
  logic [IW+ID_W-1:0] load_id_ext;
  logic [IW+ID_W-1:0] best_id_ext;

  logic [ARR_W-1:0]  in_arr;
  logic [BST_W-1:0]  in_bst;
  logic [PRI_W-1:0]  in_pri;

  assign in_arr = in_tdata[ARR_W-1:0];
  assign in_bst = in_tdata[ARR_W+BST_W-1:ARR_W];
  assign in_pri = in_tdata[IN_DATA_W-1:ARR_W+BST_W];

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid & in_tready;
  assign load_ok   = (job_cnt_r != MAX_CNT) && (in_bst != '0);
  assign load_we   = in_acc && (in_tuser[0] == MODE_LOAD) && load_ok;

  // the job id port keeps only the low 4 bits of the index
  assign load_id_ext = {{ID_W{1'b0}}, job_cnt_r[IW-1:0]};
  assign best_id_ext = {{ID_W{1'b0}}, best_r};

  // scan issues one table read per cycle until every loaded job is read
  assign issue    = (state_r == S_SCAN) && (scan_cnt_r < job_cnt_r);
  assign rd_addr  = (state_r == S_SCAN) ? scan_cnt_r[IW-1:0] : best_r;
  assign eligible = cmp_v_r && ({{(TIME_W-ARR_W){1'b0}}, arr_q_r} <= clock_r)
                    && (rem_q_r != '0);
  assign rem_dec  = rem_q_r - BST_W'(1);

  assign rem_we    = load_we || (state_r == S_UPDATE);
  assign rem_waddr = load_we ? job_cnt_r[IW-1:0] : best_r;
  assign rem_wdata = load_we ? in_bst : rem_dec;

  always_ff @(posedge clk) begin
    if (load_we) begin
      arr_mem[job_cnt_r[IW-1:0]] <= in_arr;
      bst_mem[job_cnt_r[IW-1:0]] <= in_bst;
      pri_mem[job_cnt_r[IW-1:0]] <= in_pri;
    end
    if (rem_we) begin
      rem_mem[rem_waddr] <= rem_wdata;
    end
    arr_q_r <= arr_mem[rd_addr];
    bst_q_r <= bst_mem[rd_addr];
    rem_q_r <= rem_mem[rd_addr];
    pri_q_r <= pri_mem[rd_addr];
  end

  always_comb begin
    state_nxt      = state_r;
    job_cnt_nxt    = job_cnt_r;
    done_cnt_nxt   = done_cnt_r;
    clock_nxt      = clock_r;
    scan_cnt_nxt   = scan_cnt_r;
    cmp_v_nxt      = issue;
    cmp_idx_nxt    = scan_cnt_r[IW-1:0];
    found_nxt      = found_r;
    best_nxt       = best_r;
    best_pri_nxt   = best_pri_r;
    tat_nxt        = tat_r;
    res_status_nxt = res_status_r;
    res_id_nxt     = res_id_r;
    res_fin_nxt    = res_fin_r;
    res_tat_nxt    = res_tat_r;
    res_wt_nxt     = res_wt_r;
    out_valid_nxt  = out_valid_r & ~out_tready;
    out_data_nxt   = out_data_r;
    out_user_nxt   = out_user_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          res_fin_nxt = 1'b0;
          res_tat_nxt = '0;
          res_wt_nxt  = '0;
          if (in_tuser[0] == MODE_LOAD) begin
            state_nxt = S_RESULT;
            if (load_ok) begin
              res_status_nxt = ST_LOADED;
              res_id_nxt     = load_id_ext[ID_W-1:0];
              job_cnt_nxt    = job_cnt_r + CW'(1);
            end else begin
              res_status_nxt = ST_REJECT;
              res_id_nxt     = '0;
            end
          end else begin
            state_nxt    = S_SCAN;
            scan_cnt_nxt = '0;
            found_nxt    = 1'b0;
          end
        end
      end
      S_SCAN: begin
        if (issue) begin
          scan_cnt_nxt = scan_cnt_r + CW'(1);
        end
        // strict less-than keeps the lowest id on equal priority
        if (eligible && (!found_r || (pri_q_r < best_pri_r))) begin
          found_nxt    = 1'b1;
          best_nxt     = cmp_idx_r;
          best_pri_nxt = pri_q_r;
        end
        if (!issue && !cmp_v_r) begin
          state_nxt = S_FETCH;
        end
      end
      S_FETCH: begin
        if (clock_r != '1) begin
          clock_nxt = clock_r + TIME_W'(1);
        end
        if (found_r) begin
          state_nxt = S_UPDATE;
        end else begin
          res_status_nxt = ST_IDLE;
          res_id_nxt     = '0;
          state_nxt      = S_RESULT;
        end
      end
      S_UPDATE: begin
        res_status_nxt = ST_RAN;
        res_id_nxt     = best_id_ext[ID_W-1:0];
        tat_nxt        = clock_r - {{(TIME_W-ARR_W){1'b0}}, arr_q_r};
        if (rem_dec == '0) begin
          res_fin_nxt  = 1'b1;
          done_cnt_nxt = done_cnt_r + CW'(1);
          state_nxt    = S_CALC;
        end else begin
          state_nxt    = S_RESULT;
        end
      end
      S_CALC: begin
        res_tat_nxt = tat_r;
        // waiting saturates at zero once the clock has stuck at its maximum
        if (tat_r >= {{(TIME_W-BST_W){1'b0}}, bst_q_r}) begin
          res_wt_nxt = tat_r - {{(TIME_W-BST_W){1'b0}}, bst_q_r};
        end else begin
          res_wt_nxt = '0;
        end
        state_nxt = S_RESULT;
      end
      S_RESULT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_user_nxt  = res_status_r;
          out_data_nxt  = OUT_DATA_W'({clock_r, (done_cnt_r == job_cnt_r),
                                       res_wt_r, res_tat_r, res_fin_r, res_id_r});
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      job_cnt_r   <= '0;
      done_cnt_r  <= '0;
      clock_r     <= '0;
      scan_cnt_r  <= '0;
      cmp_v_r     <= 1'b0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      job_cnt_r   <= job_cnt_nxt;
      done_cnt_r  <= done_cnt_nxt;
      clock_r     <= clock_nxt;
      scan_cnt_r  <= scan_cnt_nxt;
      cmp_v_r     <= cmp_v_nxt;
      found_r     <= found_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmp_idx_r    <= cmp_idx_nxt;
    best_r       <= best_nxt;
    best_pri_r   <= best_pri_nxt;
    tat_r        <= tat_nxt;
    res_status_r <= res_status_nxt;
    res_id_r     <= res_id_nxt;
    res_fin_r    <= res_fin_nxt;
    res_tat_r    <= res_tat_nxt;
    res_wt_r     <= res_wt_nxt;
    out_data_r   <= out_data_nxt;
    out_user_r   <= out_user_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule

[dv/testbench.sv]
// Self-checking testbench for the preemptive priority scheduler unit.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import pps_pkg::*;

  localparam int unsigned MAX_JOBS     = 16;
  localparam int unsigned N_RANDOM     = 750;
  localparam int unsigned HOLD_CYCLES  = 400;   // long receiver hold-off
  localparam int unsigned HOLD_AT      = 560;   // item count that triggers it
  localparam int unsigned DRAIN_CYCLES = 2 * (MAX_JOBS + 5);
  localparam int unsigned MAX_PRINTS   = 50;

  // one result item, unpacked from out_tuser/out_tdata
  typedef struct packed {
    status_t           status;
    logic [ID_W-1:0]   job_id;
    logic              finished;
    logic [TIME_W-1:0] turnaround;
    logic [TIME_W-1:0] waiting;
    logic              all_done;
    logic [TIME_W-1:0] now;
  } outcome_t;

  // Shadow copy of the job tables and clock; works out the outcome of each
  // accepted item and checks results against the oldest one outstanding.
  class schedule_tracker;
    logic [ARR_W-1:0]  arr_tab [MAX_JOBS];
    logic [BST_W-1:0]  bst_tab [MAX_JOBS];
    logic [BST_W-1:0]  rem_tab [MAX_JOBS];
    logic [PRI_W-1:0]  pri_tab [MAX_JOBS];
    int unsigned       n_jobs = 0;
    int unsigned       n_done = 0;
    logic [TIME_W-1:0] t_now = '0;
    outcome_t          pending_outcomes [$];
    int unsigned       errors = 0;
    int unsigned       n_rejected = 0;
    int unsigned       n_ran = 0;
    int unsigned       n_idle = 0;

    task report(string msg);
      errors++;
      if (errors <= MAX_PRINTS) $display("[%0t] mismatch: %s", $time, msg);
    endtask

    function void note_accepted(logic mode, logic [IN_DATA_W-1:0] data);
      outcome_t          o;
      logic [ARR_W-1:0]  arr;
      logic [BST_W-1:0]  bst;
      logic [PRI_W-1:0]  pri;
      logic [TIME_W-1:0] start;
      int unsigned       i;
      int unsigned       best;
      bit                found;
      o = '0;
      {pri, bst, arr} = data;
      if (mode == MODE_LOAD) begin
        if (n_jobs >= MAX_JOBS || bst == '0) begin
          o.status = ST_REJECT;
          n_rejected++;
        end else begin
          arr_tab[n_jobs] = arr;
          bst_tab[n_jobs] = bst;
          rem_tab[n_jobs] = bst;
          pri_tab[n_jobs] = pri;
          o.status = ST_LOADED;
          o.job_id = ID_W'(n_jobs);
          n_jobs++;
        end
      end else begin
        // most urgent arrived job; strict compare keeps the lowest id on a tie
        start = t_now;
        found = 1'b0;
        best  = 0;
        for (i = 0; i < n_jobs; i++) begin
          if (TIME_W'(arr_tab[i]) <= start && rem_tab[i] != '0 &&
              (!found || pri_tab[i] < pri_tab[best])) begin
            best  = i;
            found = 1'b1;
          end
        end
        if (t_now != '1) t_now++;
        if (!found) begin
          o.status = ST_IDLE;
          n_idle++;
        end else begin
          rem_tab[best]--;
          o.status = ST_RAN;
          o.job_id = ID_W'(best);
          n_ran++;
          if (rem_tab[best] == '0) begin
            o.finished   = 1'b1;
            o.turnaround = t_now - TIME_W'(arr_tab[best]);
            // only negative after clock saturation; clamp at zero
            o.waiting    = (o.turnaround >= TIME_W'(bst_tab[best])) ?
                           o.turnaround - TIME_W'(bst_tab[best]) : '0;
            n_done++;
          end
        end
      end
      o.all_done = (n_done == n_jobs);
      o.now      = t_now;
      pending_outcomes.push_back(o);
    endfunction

    task cmp_field(string name, logic [TIME_W-1:0] got, logic [TIME_W-1:0] want);
      if (got !== want)
        report($sformatf("%s got 0x%0h, expected 0x%0h", name, got, want));
    endtask

    task check_outcome(status_t user, logic [OUT_DATA_W-1:0] data);
      outcome_t got;
      outcome_t want;
      got.status     = user;
      got.job_id     = data[3:0];
      got.finished   = data[4];
      got.turnaround = data[36:5];
      got.waiting    = data[68:37];
      got.all_done   = data[69];
      got.now        = data[101:70];
      if (pending_outcomes.size() == 0) begin
        report("result item with no outstanding expectation");
      end else begin
        want = pending_outcomes.pop_front();
        cmp_field("status",     TIME_W'(got.status),   TIME_W'(want.status));
        cmp_field("job_id",     TIME_W'(got.job_id),   TIME_W'(want.job_id));
        cmp_field("finished",   TIME_W'(got.finished), TIME_W'(want.finished));
        cmp_field("turnaround", got.turnaround,        want.turnaround);
        cmp_field("waiting",    got.waiting,           want.waiting);
        cmp_field("all_done",   TIME_W'(got.all_done), TIME_W'(want.all_done));
        cmp_field("now",        got.now,               want.now);
        cmp_field("padding",    TIME_W'(data[OUT_DATA_W-1:OUT_FLD_W]), '0);
      end
    endtask
  endclass

  // ---------------------------------------------------------------------------
  // Clock, reset and DUT. Every input is known from time zero.
  // ---------------------------------------------------------------------------
  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  logic [IN_USER_W-1:0]  in_tuser   = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [OUT_USER_W-1:0] out_tuser;

  always #6 clk = ~clk;

  preemptive_priority_scheduler_unit #(
    .MAX_PROCESSES(MAX_JOBS)
  ) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),   // [15:0] arrival, [31:16] burst, [39:32] priority_req
    .in_tuser  (in_tuser),   // [0] mode
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),  // job_id, finished, turnaround, waiting, all_done, now
    .out_tuser (out_tuser)   // [1:0] status
  );

  schedule_tracker sb = new;

  // traffic shaping shared by sender and receiver
  int unsigned send_gap_pct   = 7;
  int unsigned recv_stall_pct = 69;
  bit          hold_req       = 1'b0;
  int unsigned n_holds        = 0;
  int unsigned items_sent     = 0;
  int unsigned good_loads     = 0;   // loads the table will take
  int unsigned ticks_sent     = 0;

  // Monitor: everything is sampled on the rising edge, before the DUT's
  // nonblocking updates land, so no ordering within the step matters.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) sb.check_outcome(out_tuser, out_tdata);
      if (in_tvalid && in_tready) sb.note_accepted(in_tuser[0], in_tdata);
    end
  end

  // Receiver: random stalls by phase, plus one long hold-off on request so
  // the output register and sequencer fill and in_tready drops.
  initial begin
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        n_holds++;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Sender. tvalid stays high straight into the next item unless a gap is
  // drawn, so there is never more than one assignment to it per step.
  task automatic push_item(logic mode, logic [IN_DATA_W-1:0] data);
    // idling phases: sender light/receiver heavy, then swapped, then none
    if (items_sent < 250) begin
      send_gap_pct   = 7;
      recv_stall_pct = 69;
    end else if (items_sent < 500) begin
      send_gap_pct   = 69;
      recv_stall_pct = 7;
    end else begin
      send_gap_pct   = 0;
      recv_stall_pct = 0;
    end
    if ($urandom_range(99) < send_gap_pct) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_gap_pct);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= mode;
    in_tdata  <= data;
    do @(posedge clk); while (!in_tready);
    items_sent++;
    if (items_sent == HOLD_AT) hold_req = 1'b1;
  endtask

  task automatic push_load(logic [ARR_W-1:0] arr, logic [BST_W-1:0] bst,
                           logic [PRI_W-1:0] pri);
    if (bst != '0 && good_loads < MAX_JOBS) good_loads++;
    push_item(MODE_LOAD, {pri, bst, arr});
  endtask

  // fields are ignored on a tick, so they carry noise
  task automatic push_tick(logic [IN_DATA_W-1:0] noise);
    ticks_sent++;
    push_item(MODE_TICK, noise);
  endtask

  function automatic logic [IN_DATA_W-1:0] rand_word();
    return {PRI_W'($urandom()), 32'($urandom())};
  endfunction

  // Directed: empty-table tick, zero burst, priority extremes, a late urgent job
  // run before a waiting one, a tie resolved to the lower id, run to all done.
  task automatic run_directed();
    int unsigned k;
    push_tick('0);                 // idle with nothing loaded, all_done set
    push_load(16'd5, 16'd0, 8'd7); // zero burst refused
    push_load(16'd0, 16'd3, 8'd255);
    push_load(16'd0, 16'd2, 8'd0);
    push_load(16'd2, 16'd1, 8'd0); // ties with job 1 once arrived
    push_load(16'd3, 16'd2, 8'd100);
    for (k = 0; k < 10; k++) push_tick((k % 2) ? '1 : '0);
  endtask

  // Random: loads near the current time while the table has room, the last
  // slot taken by a job of maximal arrival and burst that never arrives, then
  // mostly ticks with loads that the full table must refuse.
  task automatic run_random();
    int unsigned       k;
    int unsigned       lo;
    logic [ARR_W-1:0]  arr;
    logic [PRI_W-1:0]  pri;
    for (k = 0; k < N_RANDOM; k++) begin
      if ($urandom_range(99) < ((good_loads < MAX_JOBS) ? 6 : 4)) begin
        lo  = (ticks_sent > 20) ? ticks_sent - 20 : 0;
        arr = ARR_W'($urandom_range(ticks_sent + 30, lo));
        pri = ($urandom_range(2) == 0) ? PRI_W'($urandom_range(3)) :
                                         PRI_W'($urandom_range(255));
        if (good_loads >= MAX_JOBS)
          push_item(MODE_LOAD, rand_word());
        else if ($urandom_range(7) == 0)
          push_load(arr, '0, pri);
        else if (good_loads == MAX_JOBS - 1)
          push_load('1, '1, pri);
        else
          push_load(arr, BST_W'($urandom_range(40, 1)), pri);
      end else begin
        push_tick(rand_word());
      end
    end
  endtask

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #12_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    run_directed();
    run_random();
    in_tvalid <= 1'b0;
    while (sb.pending_outcomes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("covered %0d items: %0d jobs loaded, %0d loads refused, %0d run ticks, %0d idle",
             items_sent, sb.n_jobs, sb.n_rejected, sb.n_ran, sb.n_idle);
    $display("%0d jobs completed, clock at %0d, %0d long receiver hold-off(s), %0d mismatches",
             sb.n_done, sb.t_now, n_holds, sb.errors);
    if (sb.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
